[src/nbat_pkg.sv]
// nbat_pkg: shared widths, codes and controller/datapath handshake types
// for the nearest box association table. No dependencies.
`default_nettype none

package nbat_pkg;

    // Fixed field widths of the channels
    localparam int FUNC_W     = 2;
    localparam int COORD_IN_W = 12;
    localparam int CLASS_W    = 10;
    localparam int TIME_W     = 32;
    localparam int ACTION_W   = 3;
    localparam int SLOT_W     = 4;
    localparam int DIST_W     = 27;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [DIST_W-1:0] DIST_MAX    = '1;
    localparam logic [TIME_W-1:0] MAX_AGE_RST = 32'd2000;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_FRAME  = 2'd0,
        FUNC_DETECT = 2'd1,
        FUNC_EXPIRE = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_FRAME   = 3'd0,
        ACT_APPEND  = 3'd1,
        ACT_REPLACE = 3'd2,
        ACT_DROP    = 3'd3,
        ACT_EXPIRE  = 3'd4
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_AGE = 4'd0,
        REG_FREEZE  = 4'd1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEARCH,
        ST_EXPIRE,
        ST_COMMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic take;       // input channel ready
        logic scan_init;  // clear scan counters and best match
        logic scan_run;   // step the table scan
        logic commit;     // update table state, load result register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic item_valid;
        logic need_search;
        logic need_expire;
        logic scan_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

[src/nbat_if.sv]
// nbat_if: valid/ready channel interfaces for items, results and register writes.
// Depends on nbat_pkg.
`default_nettype none

interface nbat_item_if import nbat_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [FUNC_W-1:0]     func;
    logic [COORD_IN_W-1:0] box_left;
    logic [COORD_IN_W-1:0] box_top;
    logic [COORD_IN_W-1:0] box_right;
    logic [COORD_IN_W-1:0] box_bottom;
    logic [CLASS_W-1:0]    class_code;
    logic [TIME_W-1:0]     time_now;

    modport source (output valid, func, box_left, box_top, box_right, box_bottom,
                    class_code, time_now, input ready);
    modport sink   (input valid, func, box_left, box_top, box_right, box_bottom,
                    class_code, time_now, output ready);
endinterface

interface nbat_result_if import nbat_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot;
    logic [DIST_W-1:0]   best_distance;
    logic [COUNT_W-1:0]  removed_count;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, action, slot, best_distance, removed_count,
                    entry_count, input ready);
    modport sink   (input valid, action, slot, best_distance, removed_count,
                    entry_count, output ready);
endinterface

interface nbat_cfg_if import nbat_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/nearest_box_association_table.sv]
// nearest_box_association_table: top level, joins controller and datapath.
// Depends on nbat_pkg, nbat_if, nbat_ctrl, nbat_datapath.
//
//   channel   modport  payload                                         moves
//   --------  -------  ----------------------------------------------  -------------------
//   items     sink     func, box_left/top/right/bottom, class_code,    one item per
//                      time_now                                        transaction
//   results   source   action, slot, best_distance, removed_count,     one result per item
//                      entry_count
//   cfg       sink     index, data (0 max_age, 1 freeze_ageing)        always ready
//
// One item is in flight at a time. Frame start, append, drop, frozen expire
// and the unused code go from decode straight to commit; a replacing
// detection and an unfrozen expire check first scan the valid entries, one
// entry per cycle through the single read port of the entry memory.
// Reset clears the counts and sets the configuration to its reset values;
// the entry memory is not cleared, since only entries below the valid count
// are ever read. A new item is taken while an earlier result is still held;
// a held result stalls only the commit of the next one.
`default_nettype none

module nearest_box_association_table import nbat_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int COORD_BITS  = 12
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    nbat_item_if.sink      items,
    nbat_result_if.source  results,
    nbat_cfg_if.sink       cfg
);

    cmd_t    cmd;     // sequencing commands
    status_t status;  // scan and handshake status

    nbat_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // table memory, nearest-box search and compaction
    nbat_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .cfg     (cfg),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

`default_nettype wire

[src/nbat_ctrl.sv]
// nbat_ctrl: sequencing state machine for the association table.
// Depends on nbat_pkg; drives cmd_t, reads status_t.
`default_nettype none

module nbat_ctrl import nbat_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  status_t   status,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (status.item_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                priority if (status.need_search)
                begin
                    state_next = ST_SEARCH;
                end
                else if (status.need_expire)
                begin
                    state_next = ST_EXPIRE;
                end
                else
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_SEARCH, ST_EXPIRE:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:               cmd.take      = 1'b1;
            ST_DECODE:             cmd.scan_init = 1'b1;
            ST_SEARCH, ST_EXPIRE:  cmd.scan_run  = 1'b1;
            ST_COMMIT:             cmd.commit    = status.out_free;
            default:               cmd           = '0;
        endcase
    end

`ifndef ASSERT_OFF
    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        status.item_valid && cmd.take |=> state_reg == ST_DECODE)
        else $error("accepted item not decoded");

    a_commit_returns: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_COMMIT && status.out_free |=> state_reg == ST_IDLE)
        else $error("commit did not return to idle");

    a_scan_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEARCH && !status.scan_done |=> state_reg == ST_SEARCH)
        else $error("search left before scan done");
`endif

endmodule

`default_nettype wire

[src/nbat_datapath.sv]
// nbat_datapath: entry memory, distance pipeline, compaction, counts,
// configuration registers and result register. Depends on nbat_pkg, nbat_if.
`default_nettype none

module nbat_datapath import nbat_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int COORD_BITS  = 12
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    nbat_item_if.sink      items,
    nbat_result_if.source  results,
    nbat_cfg_if.sink       cfg,
    input  cmd_t           cmd,
    output status_t        status
);

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int SUM_W   = SQ_W + 3;
    localparam int EXT_W   = (SUM_W > DIST_W) ? SUM_W : DIST_W;
    localparam int ENTRY_W = 4 * COORD_BITS + CLASS_W + TIME_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // configuration
    logic [TIME_W-1:0] max_age_reg;
    logic              freeze_reg;

    // current item
    func_t                       func_reg;
    logic [3:0][COORD_BITS-1:0]  box_reg;
    logic [CLASS_W-1:0]          class_reg;
    logic [TIME_W-1:0]           time_reg;

    // table state
    logic [CNT_W-1:0] valid_cnt_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    // scan pipeline
    logic [CNT_W-1:0]           rd_idx_reg;
    logic                       rv_reg;
    logic [IDX_W-1:0]           ri_reg;
    logic [3:0][SQ_W-1:0]       sq_reg;
    logic                       sv_reg;
    logic [IDX_W-1:0]           si_reg;
    logic [SUM_W-1:0]           best_sum_reg;
    logic [IDX_W-1:0]           best_idx_reg;
    logic                       best_ok_reg;
    logic [CNT_W-1:0]           keep_reg;
    logic [CNT_W-1:0]           removed_reg;

    // result register
    logic                out_valid_reg;
    action_t             out_action_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [DIST_W-1:0]   out_dist_reg;
    logic [COUNT_W-1:0]  out_removed_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    logic                       load;
    logic                       expire_mode;
    logic                       is_append;
    logic                       full;
    logic                       issue;
    logic [3:0][COORD_BITS-1:0] rd_box;
    logic [TIME_W-1:0]          rd_stamp;
    logic                       expired;
    logic                       keep_wr;
    logic [3:0][COORD_BITS-1:0] abs_diff;
    logic [3:0][SQ_W-1:0]       sq_next;
    logic [SUM_W-1:0]           dist_sum;
    logic                       better;
    logic                       write_item;
    logic [IDX_W-1:0]           item_addr;
    logic [ENTRY_W-1:0]         item_entry;
    logic [EXT_W-1:0]           dist_ext;
    action_t                    res_action;
    logic [SLOT_W-1:0]          res_slot;
    logic [DIST_W-1:0]          res_dist;
    logic [COUNT_W-1:0]         res_removed;
    logic [COUNT_W-1:0]         res_count;

    assign load        = items.valid && cmd.take;
    assign items.ready = cmd.take;
    assign cfg.ready   = 1'b1;

    assign expire_mode = (func_reg == FUNC_EXPIRE);
    assign is_append   = (fill_reg >= valid_cnt_reg);
    assign full        = (valid_cnt_reg == DEPTH_CNT);
    assign issue       = cmd.scan_run && (rd_idx_reg < valid_cnt_reg);

    assign status.item_valid  = items.valid;
    assign status.need_search = (func_reg == FUNC_DETECT) && !is_append;
    assign status.need_expire = expire_mode && !freeze_reg;
    assign status.scan_done   = !(rd_idx_reg < valid_cnt_reg) && !rv_reg && !sv_reg;
    assign status.out_free    = !out_valid_reg || results.ready;

    // entry layout: {stamp, class, bottom, right, top, left}
    assign rd_stamp   = rd_data_reg[ENTRY_W-1 -: TIME_W];
    assign item_entry = {time_reg, class_reg, box_reg};

    // age is zero for a stamp in the future
    assign expired = (time_reg >= rd_stamp) && ((time_reg - rd_stamp) > max_age_reg);
    assign keep_wr = rv_reg && expire_mode && !expired;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            rd_box[k]   = rd_data_reg[k*COORD_BITS +: COORD_BITS];
            abs_diff[k] = (box_reg[k] >= rd_box[k]) ? (box_reg[k] - rd_box[k])
                                                    : (rd_box[k] - box_reg[k]);
            sq_next[k]  = SQ_W'(abs_diff[k]) * SQ_W'(abs_diff[k]);
        end
    end

    // each coordinate appears in two corners
    assign dist_sum = (SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2])
                       + SUM_W'(sq_reg[3])) << 1;
    assign better   = !best_ok_reg || (dist_sum < best_sum_reg);

    assign write_item = cmd.commit && (func_reg == FUNC_DETECT) && !(is_append && full);
    assign item_addr  = is_append ? valid_cnt_reg[IDX_W-1:0] : best_idx_reg;
    assign dist_ext   = EXT_W'(best_sum_reg);

    // result of the item being committed
    always_comb
    begin
        res_action  = ACT_EXPIRE;
        res_slot    = '0;
        res_dist    = '0;
        res_removed = '0;
        res_count   = COUNT_W'(valid_cnt_reg);
        unique case (func_reg)
            FUNC_FRAME:
            begin
                res_action = ACT_FRAME;
            end
            FUNC_DETECT:
            begin
                if (is_append)
                begin
                    if (full)
                    begin
                        res_action = ACT_DROP;
                    end
                    else
                    begin
                        res_action = ACT_APPEND;
                        res_slot   = SLOT_W'(valid_cnt_reg);
                        res_count  = COUNT_W'(valid_cnt_reg + 1'b1);
                    end
                end
                else
                begin
                    res_action = ACT_REPLACE;
                    res_slot   = SLOT_W'(best_idx_reg);
                    res_dist   = (dist_ext > EXT_W'(DIST_MAX)) ? DIST_MAX
                                                                : DIST_W'(dist_ext);
                end
            end
            FUNC_EXPIRE:
            begin
                if (!freeze_reg)
                begin
                    res_removed = COUNT_W'(removed_reg);
                    res_count   = COUNT_W'(keep_reg);
                end
            end
            FUNC_NONE:
            begin
                res_action = ACT_EXPIRE;
            end
            default:
            begin
                res_action = ACT_EXPIRE;
            end
        endcase
    end

    // memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (write_item)
        begin
            mem[item_addr] <= item_entry;
        end
        else if (keep_wr)
        begin
            mem[keep_reg[IDX_W-1:0]] <= rd_data_reg;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            func_reg   <= func_t'(items.func);
            box_reg[0] <= COORD_BITS'(items.box_left);
            box_reg[1] <= COORD_BITS'(items.box_top);
            box_reg[2] <= COORD_BITS'(items.box_right);
            box_reg[3] <= COORD_BITS'(items.box_bottom);
            class_reg  <= items.class_code;
            time_reg   <= items.time_now;
        end
        if (issue)
        begin
            ri_reg <= rd_idx_reg[IDX_W-1:0];
        end
        sq_reg <= sq_next;
        si_reg <= ri_reg;
        if (sv_reg && better)
        begin
            best_sum_reg <= dist_sum;
            best_idx_reg <= si_reg;
        end
        if (cmd.commit)
        begin
            out_action_reg  <= res_action;
            out_slot_reg    <= res_slot;
            out_dist_reg    <= res_dist;
            out_removed_reg <= res_removed;
            out_count_reg   <= res_count;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_age_reg   <= MAX_AGE_RST;
            freeze_reg    <= 1'b0;
            valid_cnt_reg <= '0;
            fill_reg      <= '0;
            rd_idx_reg    <= '0;
            rv_reg        <= 1'b0;
            sv_reg        <= 1'b0;
            best_ok_reg   <= 1'b0;
            keep_reg      <= '0;
            removed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                if (cfg.index == REG_MAX_AGE)
                begin
                    max_age_reg <= cfg.data;
                end
                else if (cfg.index == REG_FREEZE)
                begin
                    freeze_reg <= cfg.data[0];
                end
            end

            if (cmd.scan_init)
            begin
                rd_idx_reg  <= '0;
                rv_reg      <= 1'b0;
                sv_reg      <= 1'b0;
                best_ok_reg <= 1'b0;
                keep_reg    <= '0;
                removed_reg <= '0;
            end
            else
            begin
                rv_reg <= issue;
                sv_reg <= rv_reg && !expire_mode;
                if (issue)
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
                if (sv_reg && better)
                begin
                    best_ok_reg <= 1'b1;
                end
                if (rv_reg && expire_mode)
                begin
                    if (expired)
                    begin
                        removed_reg <= removed_reg + 1'b1;
                    end
                    else
                    begin
                        keep_reg <= keep_reg + 1'b1;
                    end
                end
            end

            if (cmd.commit)
            begin
                unique case (func_reg)
                    FUNC_FRAME:
                    begin
                        fill_reg <= '0;
                    end
                    FUNC_DETECT:
                    begin
                        if (is_append && !full)
                        begin
                            valid_cnt_reg <= valid_cnt_reg + 1'b1;
                        end
                        if (fill_reg < DEPTH_CNT)
                        begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                    end
                    FUNC_EXPIRE:
                    begin
                        if (!freeze_reg)
                        begin
                            valid_cnt_reg <= keep_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.action        = out_action_reg;
    assign results.slot          = out_slot_reg;
    assign results.best_distance = out_dist_reg;
    assign results.removed_count = out_removed_reg;
    assign results.entry_count   = out_count_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_cnt_reg <= DEPTH_CNT)
        else $error("entry count above table depth");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH_CNT)
        else $error("fill count above table depth");

    a_compact_tally: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg && expire_mode |-> (keep_reg + removed_reg) == CNT_W'(ri_reg))
        else $error("kept plus removed does not match scan position");

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !out_valid_reg || results.ready)
        else $error("result register overwritten while held");
`endif

endmodule

`default_nettype wire

[tb/tb_nearest_box_association_table.sv]
`timescale 1ns / 100ps
// tb_nearest_box_association_table: self-checking bench for the nearest box table.
// Depends on nbat_pkg, nbat_if (channel interfaces) and nearest_box_association_table.

module tb_nearest_box_association_table;
    import nbat_pkg::*;

    localparam int DEPTH         = 16;
    localparam int SETTLE_CYCLES = 24;      // longer than the slowest item (a replace on a full table)
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 150;
    localparam int CALM_ITEMS    = 100;     // tail of the run with no idling on either side
    localparam int LONG_HOLD     = 250;     // one long receiver stall to back up the block
    localparam int LONG_HOLD_AT  = 300;     // ... after this many results

    // What the stimulus queue holds: an item, a register write, or a drain point
    // where the sender waits for every outstanding result.
    typedef enum int { OP_ITEM, OP_CFG, OP_SYNC } op_kind_t;

    typedef struct {
        op_kind_t              kind;
        func_t                 func;
        logic [COORD_IN_W-1:0] left;
        logic [COORD_IN_W-1:0] top;
        logic [COORD_IN_W-1:0] right;
        logic [COORD_IN_W-1:0] bottom;
        logic [CLASS_W-1:0]    cls;
        logic [TIME_W-1:0]     now;
        cfg_reg_t              reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        int                    gap;
    } stim_op_t;

    typedef struct {
        action_t            action;
        logic [SLOT_W-1:0]  slot;
        logic [DIST_W-1:0]  distance;
        logic [COUNT_W-1:0] removed;
        logic [COUNT_W-1:0] count;
    } track_result_t;

    logic clk;
    logic rst_n;

    nbat_item_if   items_ch ();
    nbat_result_if results_ch ();
    nbat_cfg_if    cfg_ch ();

    nearest_box_association_table uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch),
        .cfg     (cfg_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Table model: shadow copy of the tracked boxes, counts and registers
    // ------------------------------------------------------------------
    logic [COORD_IN_W-1:0] trk_box   [DEPTH][4];
    logic [CLASS_W-1:0]    trk_class [DEPTH];
    logic [TIME_W-1:0]     trk_stamp [DEPTH];
    int unsigned           trk_count  = 0;
    int unsigned           fill_count = 0;
    logic [TIME_W-1:0]     age_limit  = MAX_AGE_RST;
    logic                  frozen     = 1'b0;

    function automatic longint unsigned sq_gap(logic [COORD_IN_W-1:0] a, logic [COORD_IN_W-1:0] b);
        longint unsigned d;
        d = (a > b) ? longint'(a - b) : longint'(b - a);
        return d * d;
    endfunction

    // Sum over all four corners reduces to twice the per-edge squared offsets.
    function automatic longint unsigned box_distance(stim_op_t it, int unsigned idx);
        return 2 * (sq_gap(it.left,  trk_box[idx][0]) + sq_gap(it.top,    trk_box[idx][1]) +
                    sq_gap(it.right, trk_box[idx][2]) + sq_gap(it.bottom, trk_box[idx][3]));
    endfunction

    function automatic track_result_t table_step(stim_op_t it);
        track_result_t   res;
        int unsigned     best;
        int unsigned     keep;
        longint unsigned dmin;
        longint unsigned d;
        logic [TIME_W-1:0] age;
        res = '{action: ACT_EXPIRE, slot: '0, distance: '0, removed: '0, count: '0};
        case (it.func)
            FUNC_FRAME:
            begin
                fill_count = 0;
                res.action = ACT_FRAME;
            end
            FUNC_DETECT:
            begin
                if (fill_count >= trk_count)
                begin
                    if (trk_count >= DEPTH)
                        res.action = ACT_DROP;
                    else
                    begin
                        best = trk_count;
                        trk_count++;
                        res.action = ACT_APPEND;
                        res.slot = SLOT_W'(best);
                    end
                end
                else
                begin
                    // nearest stored box; strict compare keeps the lowest index on ties
                    best = 0;
                    dmin = box_distance(it, 0);
                    for (int unsigned i = 1; i < trk_count; i++)
                    begin
                        d = box_distance(it, i);
                        if (d < dmin)
                        begin
                            dmin = d;
                            best = i;
                        end
                    end
                    res.action = ACT_REPLACE;
                    res.slot = SLOT_W'(best);
                    res.distance = (dmin > DIST_MAX) ? DIST_MAX : dmin[DIST_W-1:0];
                end
                if (res.action != ACT_DROP)
                begin
                    trk_box[best][0] = it.left;
                    trk_box[best][1] = it.top;
                    trk_box[best][2] = it.right;
                    trk_box[best][3] = it.bottom;
                    trk_class[best]  = it.cls;
                    trk_stamp[best]  = it.now;
                end
                if (fill_count < DEPTH)
                    fill_count++;
            end
            FUNC_EXPIRE:
            begin
                if (!frozen)
                begin
                    // stamps in the future count as age zero, no wrap
                    keep = 0;
                    for (int unsigned i = 0; i < trk_count; i++)
                    begin
                        age = (it.now >= trk_stamp[i]) ? it.now - trk_stamp[i] : '0;
                        if (age > age_limit)
                            res.removed++;
                        else
                        begin
                            trk_box[keep]   = trk_box[i];
                            trk_class[keep] = trk_class[i];
                            trk_stamp[keep] = trk_stamp[i];
                            keep++;
                        end
                    end
                    trk_count = keep;
                end
            end
            default: ;  // unused code: nothing changes, answered like an expire
        endcase
        res.count = COUNT_W'(trk_count);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus queue and generation helpers
    // ------------------------------------------------------------------
    stim_op_t          stim_q [$];
    track_result_t     result_due [$];
    logic [COORD_IN_W-1:0] anchor [DEPTH][4];   // loose track positions for near-miss detections
    logic [TIME_W-1:0] gen_clock;
    int                calm_from    = 32'h7fffffff;
    int                items_taken  = 0;
    int                results_seen = 0;
    int                err_count    = 0;
    int                cycle_cnt    = 0;
    logic              item_taken   = 1'b0;
    logic              cfg_taken    = 1'b0;

    function automatic logic [COORD_IN_W-1:0] rnd_coord();
        return COORD_IN_W'($urandom_range(0, 4095));
    endfunction

    function automatic logic [CLASS_W-1:0] rnd_class();
        return CLASS_W'($urandom_range(0, 1023));
    endfunction

    function automatic int pick_gap(bit busy);
        if (busy || $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(1, 4);
    endfunction

    function automatic logic [COORD_IN_W-1:0] nudge(logic [COORD_IN_W-1:0] v);
        int t;
        t = int'(v) + int'($urandom_range(0, 16)) - 8;
        if (t < 0)
            t = 0;
        if (t > 4095)
            t = 4095;
        return COORD_IN_W'(t);
    endfunction

    task automatic enqueue_op(stim_op_t op);
        stim_q.insert(stim_q.size(), op);
    endtask

    task automatic push_item(func_t f, logic [COORD_IN_W-1:0] l, logic [COORD_IN_W-1:0] tp,
                             logic [COORD_IN_W-1:0] r, logic [COORD_IN_W-1:0] b,
                             logic [CLASS_W-1:0] c, logic [TIME_W-1:0] t, int gap);
        stim_op_t op;
        op = '{kind: OP_ITEM, func: f, left: l, top: tp, right: r, bottom: b, cls: c, now: t,
               reg_idx: REG_MAX_AGE, reg_data: '0, gap: gap};
        enqueue_op(op);
    endtask

    task automatic push_sync();
        stim_op_t op;
        op = '{kind: OP_SYNC, func: FUNC_NONE, left: '0, top: '0, right: '0, bottom: '0,
               cls: '0, now: '0, reg_idx: REG_MAX_AGE, reg_data: '0, gap: 0};
        enqueue_op(op);
    endtask

    // register writes only once the block has drained
    task automatic push_cfg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
        stim_op_t op;
        push_sync();
        op = '{kind: OP_CFG, func: FUNC_NONE, left: '0, top: '0, right: '0, bottom: '0,
               cls: '0, now: '0, reg_idx: r, reg_data: d, gap: 0};
        enqueue_op(op);
    endtask

    task automatic push_random_detect(bit busy);
        int j;
        logic [TIME_W-1:0] stamp;
        j = $urandom_range(0, DEPTH - 1);
        if ($urandom_range(0, 9) < 3)
        begin
            for (int k = 0; k < 4; k++)
                anchor[j][k] = rnd_coord();
        end
        else
        begin
            for (int k = 0; k < 4; k++)
                anchor[j][k] = nudge(anchor[j][k]);
        end
        stamp = gen_clock + $urandom_range(0, 20);
        if ($urandom_range(0, 19) == 0)
            stamp = gen_clock + $urandom_range(1000, 100000);   // stamp ahead of the clock
        push_item(FUNC_DETECT, anchor[j][0], anchor[j][1], anchor[j][2], anchor[j][3],
                  rnd_class(), stamp, pick_gap(busy));
    endtask

    // Mostly well-formed frames: frame start, a run of detections, an expire check.
    // A little noise: unused codes and expire checks at odd times.
    task automatic gen_phase(int n_items, bit mid_pause);
        int  start;
        int  k;
        bit  busy;
        bit  paused;
        start  = stim_q.size();
        paused = 1'b0;
        gen_clock += $urandom;
        while (stim_q.size() - start < n_items)
        begin
            busy = ($urandom_range(0, 3) == 0);
            push_item(FUNC_FRAME, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                      rnd_class(), $urandom, pick_gap(busy));
            k = $urandom_range(0, 18);
            for (int i = 0; i < k; i++)
                push_random_detect(busy);
            if ($urandom_range(0, 1) == 0)
                push_item(FUNC_EXPIRE, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                          rnd_class(), gen_clock + $urandom_range(0, 50), pick_gap(busy));
            if ($urandom_range(0, 9) == 0)
                push_item($urandom_range(0, 1) ? FUNC_NONE : FUNC_EXPIRE,
                          rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                          rnd_class(), $urandom, pick_gap(busy));
            if (mid_pause && !paused && stim_q.size() - start > n_items / 2)
            begin
                push_sync();    // sender holds until every result is back
                paused = 1'b1;
            end
            gen_clock += $urandom_range(1, 400);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: inputs change on the falling edge
    // ------------------------------------------------------------------
    int gap_left   = 0;
    int settle_cnt = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            items_ch.valid <= 1'b0;
            cfg_ch.valid   <= 1'b0;
        end
        else if (items_ch.valid && !item_taken)
        begin
            // transaction still offered, hold everything
        end
        else if (cfg_ch.valid && !cfg_taken)
        begin
            // register write still offered
        end
        else if (gap_left > 0)
        begin
            gap_left       <= gap_left - 1;
            items_ch.valid <= 1'b0;
            cfg_ch.valid   <= 1'b0;
        end
        else if (stim_q.size() == 0)
        begin
            items_ch.valid <= 1'b0;
            cfg_ch.valid   <= 1'b0;
        end
        else
        begin
            case (stim_q[0].kind)
                OP_ITEM:
                begin
                    items_ch.func       <= stim_q[0].func;
                    items_ch.box_left   <= stim_q[0].left;
                    items_ch.box_top    <= stim_q[0].top;
                    items_ch.box_right  <= stim_q[0].right;
                    items_ch.box_bottom <= stim_q[0].bottom;
                    items_ch.class_code <= stim_q[0].cls;
                    items_ch.time_now   <= stim_q[0].now;
                    items_ch.valid      <= 1'b1;
                    cfg_ch.valid        <= 1'b0;
                    gap_left            <= stim_q[0].gap;
                    stim_q.pop_front();
                end
                OP_CFG:
                begin
                    cfg_ch.index   <= stim_q[0].reg_idx;
                    cfg_ch.data    <= stim_q[0].reg_data;
                    cfg_ch.valid   <= 1'b1;
                    items_ch.valid <= 1'b0;
                    stim_q.pop_front();
                end
                default:
                begin
                    // drain point: all results back, then a quiet spell counted by settle_cnt
                    items_ch.valid <= 1'b0;
                    cfg_ch.valid   <= 1'b0;
                    if (result_due.size() != 0)
                        settle_cnt <= 0;
                    else if (settle_cnt >= SETTLE_CYCLES)
                    begin
                        settle_cnt <= 0;
                        stim_q.pop_front();
                    end
                    else
                        settle_cnt <= settle_cnt + 1;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: short random stalls, one long stall, calm tail
    // ------------------------------------------------------------------
    int short_hold = 0;
    int long_hold  = 0;
    bit long_done  = 1'b0;

    always @(negedge clk)
    begin
        if (!rst_n)
            results_ch.ready <= 1'b0;
        else if (long_hold > 0)
        begin
            results_ch.ready <= 1'b0;
            long_hold        <= long_hold - 1;
        end
        else if (!long_done && results_seen >= LONG_HOLD_AT)
        begin
            // block fills up with one result held and one item pending
            results_ch.ready <= 1'b0;
            long_hold        <= LONG_HOLD;
            long_done        <= 1'b1;
        end
        else if (short_hold > 0)
        begin
            results_ch.ready <= 1'b0;
            short_hold       <= short_hold - 1;
        end
        else if (items_taken < calm_from && cycle_cnt[7:6] != 2'b11 && $urandom_range(0, 5) == 0)
        begin
            results_ch.ready <= 1'b0;
            short_hold       <= $urandom_range(0, 3);
        end
        else
            results_ch.ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Monitor: transactions sampled on the rising edge
    // ------------------------------------------------------------------
    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        track_result_t want;
        stim_op_t      seen;
        cycle_cnt <= cycle_cnt + 1;
        if (!rst_n)
        begin
            item_taken <= 1'b0;
            cfg_taken  <= 1'b0;
        end
        else
        begin
            item_taken <= items_ch.valid && items_ch.ready;
            cfg_taken  <= cfg_ch.valid && cfg_ch.ready;

            if (results_ch.valid && results_ch.ready)
            begin
                results_seen <= results_seen + 1;
                if (result_due.size() == 0)
                begin
                    $error("result transaction with nothing expected, action %0d",
                           results_ch.action);
                    err_count++;
                end
                else
                begin
                    want = result_due.pop_front();
                    check_field("action",        64'(want.action),   64'(results_ch.action));
                    check_field("slot",          64'(want.slot),     64'(results_ch.slot));
                    check_field("best_distance", 64'(want.distance),
                                64'(results_ch.best_distance));
                    check_field("removed_count", 64'(want.removed),
                                64'(results_ch.removed_count));
                    check_field("entry_count",   64'(want.count),
                                64'(results_ch.entry_count));
                end
            end

            if (items_ch.valid && items_ch.ready)
            begin
                seen = '{kind: OP_ITEM, func: func_t'(items_ch.func), left: items_ch.box_left,
                         top: items_ch.box_top, right: items_ch.box_right,
                         bottom: items_ch.box_bottom, cls: items_ch.class_code,
                         now: items_ch.time_now, reg_idx: REG_MAX_AGE, reg_data: '0, gap: 0};
                result_due.insert(result_due.size(), table_step(seen));
                items_taken <= items_taken + 1;
            end

            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_reg_t'(cfg_ch.index))
                    REG_MAX_AGE: age_limit = cfg_ch.data;
                    REG_FREEZE:  frozen    = cfg_ch.data[0];
                    default: ;
                endcase
            end
        end

        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build stimulus, reset, wait for drain, report
    // ------------------------------------------------------------------
    initial
    begin : main
        int n_items;
        int tail;
        rst_n               = 1'b0;
        items_ch.valid      = 1'b0;
        items_ch.func       = FUNC_FRAME;
        items_ch.box_left   = '0;
        items_ch.box_top    = '0;
        items_ch.box_right  = '0;
        items_ch.box_bottom = '0;
        items_ch.class_code = '0;
        items_ch.time_now   = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_MAX_AGE;
        cfg_ch.data         = '0;
        results_ch.ready    = 1'b0;

        for (int i = 0; i < DEPTH; i++)
            for (int k = 0; k < 4; k++)
                anchor[i][k] = rnd_coord();
        gen_clock = '0;

        // Directed: unused code on an empty table, fill all 16 slots in one frame
        // (zero box and all-ones box among them, one stamp far in the future),
        // drop on the full table, replacements (one an exact match), expire checks.
        push_item(FUNC_NONE, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 10'h3ff, 32'hffffffff,
                  pick_gap(1'b0));
        push_item(FUNC_FRAME, '0, '0, '0, '0, '0, '0, pick_gap(1'b0));
        push_item(FUNC_DETECT, '0, '0, '0, '0, '0, '0, pick_gap(1'b0));
        push_item(FUNC_DETECT, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 10'h3ff, 32'hffffffff,
                  pick_gap(1'b0));
        for (int i = 2; i < DEPTH; i++)
            push_item(FUNC_DETECT, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                      rnd_class(), TIME_W'(100 * i), pick_gap(1'b0));
        push_item(FUNC_DETECT, 12'h800, 12'h400, 12'h200, 12'h100, 10'h155, 32'd1700,
                  pick_gap(1'b0));
        push_item(FUNC_FRAME, '0, '0, '0, '0, '0, '0, pick_gap(1'b0));
        push_item(FUNC_DETECT, '0, '0, '0, '0, 10'h2aa, 32'd1000, pick_gap(1'b0));
        push_item(FUNC_DETECT, '0, 12'hfff, '0, 12'hfff, 10'h3ff, 32'd4000, pick_gap(1'b0));
        push_item(FUNC_EXPIRE, '0, '0, '0, '0, '0, 32'd5000, pick_gap(1'b0));
        push_item(FUNC_EXPIRE, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 10'h3ff, 32'hffffffff,
                  pick_gap(1'b0));
        push_item(FUNC_NONE, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                  rnd_class(), $urandom, pick_gap(1'b0));

        // Random phases under different register settings
        gen_phase(PHASE_ITEMS, 1'b0);                 // reset values
        push_cfg(REG_MAX_AGE, '0);                    // anything stamped in the past goes
        push_cfg(REG_FREEZE, 32'd0);
        gen_phase(PHASE_ITEMS, 1'b0);
        push_cfg(REG_FREEZE, 32'hffffffff);           // only bit 0 counts
        gen_phase(PHASE_ITEMS, 1'b1);
        push_cfg(REG_FREEZE, 32'd0);
        push_cfg(REG_MAX_AGE, 32'hffffffff);          // nothing can age out
        gen_phase(PHASE_ITEMS, 1'b0);
        push_cfg(REG_MAX_AGE, $urandom_range(200, 3000));
        gen_phase(PHASE_ITEMS, 1'b0);
        push_cfg(REG_MAX_AGE, MAX_AGE_RST);
        gen_phase(PHASE_ITEMS, 1'b0);

        // no sender gaps in the tail
        n_items = 0;
        tail    = 0;
        foreach (stim_q[i])
            if (stim_q[i].kind == OP_ITEM)
                n_items++;
        for (int i = stim_q.size() - 1; i >= 0 && tail < CALM_ITEMS; i--)
            if (stim_q[i].kind == OP_ITEM)
            begin
                stim_q[i].gap = 0;
                tail++;
            end
        calm_from = n_items - CALM_ITEMS;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || items_ch.valid || cfg_ch.valid || result_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (err_count == 0 && result_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[nearest_box_association_table.f]
src/nbat_pkg.sv
src/nbat_if.sv
src/nbat_ctrl.sv
src/nbat_datapath.sv
src/nearest_box_association_table.sv
tb/tb_nearest_box_association_table.sv
